[sv/ffha_pkg.sv]
// Package for the first-fit heap allocator: sizes, opcodes and state codes.
// Depends on nothing; used by every module of the allocator.
package ffha_pkg;

   localparam int unsigned PoolBytesDefault   = 4194304;
   localparam int unsigned HeaderBytesDefault = 12;
   localparam int unsigned MaxBlocksDefault   = 64;
   localparam int unsigned AlignBytesDefault  = 4;
   localparam int unsigned MinSplitPayload    = 4;

   localparam int unsigned OpcodeWidth = 2;
   localparam int unsigned ReqWidth    = 23;
   localparam int unsigned OffWidth    = 22;
   localparam int unsigned SizeWidth   = 22;
   localparam int unsigned UsedWidth   = 23;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_RESET = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_REQ,
      ST_SCAN_CHK,
      ST_SHIFT_REQ,
      ST_SHIFT_WR,
      ST_SPLIT_WR,
      ST_MARK_WR,
      ST_MERGE_REQ,
      ST_MERGE_CHK,
      ST_PULL_REQ,
      ST_PULL_WR,
      ST_RESP
   } state_type;

endpackage

[sv/first_fit_heap_allocator_unit.sv]
// First-fit heap allocator with coalescing.
// Channels: req_ (opcode, request_size, payload_offset) and rsp_ (ok,
// granted_offset, used_bytes, free_bytes), each with valid and stall;
// a word moves when valid is high and stall is low.
// One item is handled at a time. Allocate walks the block table one entry at a
// time through the table memory's read port, then shifts entries up to open a
// slot when a block is split (a read and a write per moved entry) and writes
// the remainder and the granted entry. Free walks to the block, writes it free,
// then sweeps the table merging free neighbors, one entry visited or moved at a
// time. A null free or an undefined opcode skips the table and goes straight to
// its result, and the next word is taken the cycle after the result leaves.
// The single read port of the table memory sets the pace of the walks and moves.
// Reset (and the reset opcode) runs a clearing pass that writes one
// free block spanning the pool; no word is taken during it.
// The result is held in an output register; while the receiver stalls it
// stays unchanged and req_stall stays high.
// Depends on ffha_pkg, ffha_table and ffha_ctrl.
module first_fit_heap_allocator_unit #(
   parameter int unsigned PoolBytes   = ffha_pkg::PoolBytesDefault,
   parameter int unsigned HeaderBytes = ffha_pkg::HeaderBytesDefault,
   parameter int unsigned MaxBlocks   = ffha_pkg::MaxBlocksDefault,
   parameter int unsigned AlignBytes  = ffha_pkg::AlignBytesDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ffha_pkg::OpcodeWidth-1:0] req_opcode,
   input  logic [ffha_pkg::ReqWidth-1:0]    req_request_size,
   input  logic [ffha_pkg::OffWidth-1:0]    req_payload_offset,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic [ffha_pkg::OffWidth-1:0]    rsp_granted_offset,
   output logic [ffha_pkg::UsedWidth-1:0]   rsp_used_bytes,
   output logic [ffha_pkg::UsedWidth-1:0]   rsp_free_bytes
);
   import ffha_pkg::*;

   localparam int unsigned IdxWidth = $clog2(MaxBlocks);

   logic                 rd_en, wr_en, rd_used, wr_used;
   logic [IdxWidth-1:0]  rd_addr, wr_addr;
   logic [SizeWidth-1:0] rd_size, wr_size;

   ffha_ctrl #(
      .PoolBytes(PoolBytes), .HeaderBytes(HeaderBytes),
      .MaxBlocks(MaxBlocks), .AlignBytes(AlignBytes), .IdxWidth(IdxWidth)
   ) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_request_size,
      .req_payload_offset, .rsp_valid, .rsp_stall, .rsp_ok, .rsp_granted_offset,
      .rsp_used_bytes, .rsp_free_bytes, .rd_en, .rd_addr, .rd_size, .rd_used,
      .wr_en, .wr_addr, .wr_size, .wr_used
   );

   ffha_table #(.MaxBlocks(MaxBlocks), .IdxWidth(IdxWidth)) u_table (
      .clock, .rd_en, .rd_addr, .rd_size, .rd_used,
      .wr_en, .wr_addr, .wr_size, .wr_used
   );

endmodule

[sv/ffha_table.sv]
// Block table memory for the allocator: size and used mark per block.
// Depends on ffha_pkg; one write port and one read port, registered read data.
module ffha_table #(
   parameter int unsigned MaxBlocks = ffha_pkg::MaxBlocksDefault,
   parameter int unsigned IdxWidth  = $clog2(MaxBlocks)
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [IdxWidth-1:0]            rd_addr,
   output logic [ffha_pkg::SizeWidth-1:0] rd_size,
   output logic                           rd_used,
   input  logic                           wr_en,
   input  logic [IdxWidth-1:0]            wr_addr,
   input  logic [ffha_pkg::SizeWidth-1:0] wr_size,
   input  logic                           wr_used
);
   import ffha_pkg::*;

   logic [SizeWidth:0] mem [MaxBlocks];
   logic [SizeWidth:0] rd_word_ff;

   // Write then registered read; entries have no reset, the clearing pass writes entry 0.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_used, wr_size};
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_used = rd_word_ff[SizeWidth];
   assign rd_size = rd_word_ff[SizeWidth-1:0];

endmodule

[sv/ffha_ctrl.sv]
// Sequencer for the allocator: walks, splits, shifts and merges the block table.
// Depends on ffha_pkg; drives the ffha_table ports.
module ffha_ctrl #(
   parameter int unsigned PoolBytes   = ffha_pkg::PoolBytesDefault,
   parameter int unsigned HeaderBytes = ffha_pkg::HeaderBytesDefault,
   parameter int unsigned MaxBlocks   = ffha_pkg::MaxBlocksDefault,
   parameter int unsigned AlignBytes  = ffha_pkg::AlignBytesDefault,
   parameter int unsigned IdxWidth    = $clog2(MaxBlocks)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ffha_pkg::OpcodeWidth-1:0] req_opcode,
   input  logic [ffha_pkg::ReqWidth-1:0]    req_request_size,
   input  logic [ffha_pkg::OffWidth-1:0]    req_payload_offset,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic [ffha_pkg::OffWidth-1:0]    rsp_granted_offset,
   output logic [ffha_pkg::UsedWidth-1:0]   rsp_used_bytes,
   output logic [ffha_pkg::UsedWidth-1:0]   rsp_free_bytes,
   output logic                             rd_en,
   output logic [IdxWidth-1:0]              rd_addr,
   input  logic [ffha_pkg::SizeWidth-1:0]   rd_size,
   input  logic                             rd_used,
   output logic                             wr_en,
   output logic [IdxWidth-1:0]              wr_addr,
   output logic [ffha_pkg::SizeWidth-1:0]   wr_size,
   output logic                             wr_used
);
   import ffha_pkg::*;

   localparam int unsigned CntWidth = $clog2(MaxBlocks + 1);
   localparam int unsigned AccWidth = 26;
   localparam logic [CntWidth-1:0] CntMax = CntWidth'(MaxBlocks);
   localparam logic [CntWidth-1:0] CntOne = CntWidth'(1);
   localparam logic [AccWidth-1:0] Hdr = AccWidth'(HeaderBytes);
   localparam logic [AccWidth-1:0] SplitMin = AccWidth'(HeaderBytes + MinSplitPayload);
   localparam logic [SizeWidth-1:0] FullSize = SizeWidth'(PoolBytes - HeaderBytes);
   localparam logic [UsedWidth-1:0] PoolWord = UsedWidth'(PoolBytes);
   localparam logic [AccWidth-1:0] AlignMask = AccWidth'(AlignBytes - 1);

   state_type state_ff, state_in;

   logic [CntWidth-1:0]   count_ff, count_in;
   logic [CntWidth-1:0]   idx_ff, idx_in;
   logic [CntWidth-1:0]   ptr_ff, ptr_in;
   logic [UsedWidth-1:0]  used_ff, used_in;
   logic [AccWidth-1:0]   start_ff, start_in;
   logic [AccWidth-1:0]   need_ff, need_in;
   logic [SizeWidth-1:0]  size_ff, size_in;
   logic [SizeWidth-1:0]  prev_size_ff, prev_size_in;
   logic                  prev_free_ff, prev_free_in;
   logic [SizeWidth-1:0]  hold_size_ff, hold_size_in;
   logic                  hold_used_ff, hold_used_in;
   logic                  is_free_ff, is_free_in;
   logic [OffWidth-1:0]   off_ff, off_in;
   logic                  ok_ff, ok_in;
   logic [OffWidth-1:0]   grant_ff, grant_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [AccWidth-1:0]   rd_size_w;
   logic [AccWidth-1:0]   start_next;
   logic                  fits;
   logic                  can_split;
   logic                  accept;
   logic                  fold;
   logic [SizeWidth-1:0]  fold_size;
   logic [IdxWidth-1:0]   idx_lo;

   assign accept     = req_valid && !req_stall;
   assign rd_size_w  = AccWidth'(rd_size);
   assign start_next = start_ff + Hdr + rd_size_w;
   assign fits       = !rd_used && (rd_size_w >= need_ff);
   assign can_split  = (rd_size_w >= need_ff + SplitMin) && (count_ff < CntMax);
   assign fold       = prev_free_ff && !rd_used;
   assign fold_size  = SizeWidth'(AccWidth'(prev_size_ff) + Hdr + rd_size_w);
   assign idx_lo     = idx_ff[IdxWidth-1:0];

   // Next state and working registers.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      used_in      = used_ff;
      start_in     = start_ff;
      need_in      = need_ff;
      size_in      = size_ff;
      prev_size_in = prev_size_ff;
      prev_free_in = prev_free_ff;
      hold_size_in = hold_size_ff;
      hold_used_in = hold_used_ff;
      is_free_in   = is_free_ff;
      off_in       = off_ff;
      ok_in        = ok_ff;
      grant_in     = grant_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            // Clearing pass writes entry 0 only; count bounds all reads.
            // The reset opcode leaves ok set and still owes its result word.
            state_in = ok_ff ? ST_RESP : ST_IDLE;
            count_in = CntOne;
            used_in  = '0;
         end
         ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               start_in = '0;
               need_in  = (AccWidth'(req_request_size) + AlignMask) & ~AlignMask;
               off_in   = req_payload_offset;
               ok_in    = 1'b0;
               grant_in = '0;
               is_free_in = (opcode_type'(req_opcode) == OP_FREE);
               unique case (opcode_type'(req_opcode))
                  OP_ALLOC: state_in = ST_SCAN_REQ;
                  OP_FREE: begin
                     if (req_payload_offset == '0) begin
                        ok_in    = 1'b1;
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_SCAN_REQ;
                     end
                  end
                  OP_RESET: begin
                     ok_in    = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN_REQ: begin
            state_in = (idx_ff < count_ff) ? ST_SCAN_CHK : ST_RESP;
         end
         ST_SCAN_CHK: begin
            size_in  = rd_size;
            start_in = start_next;
            idx_in   = idx_ff + CntOne;
            state_in = ST_SCAN_REQ;
            if (is_free_ff) begin
               if (start_ff + Hdr == AccWidth'(off_ff)) begin
                  idx_in = idx_ff;
                  if (rd_used) begin
                     // Release the block, then sweep for free neighbors.
                     ok_in        = 1'b1;
                     used_in      = used_ff - UsedWidth'(rd_size_w + Hdr);
                     hold_size_in = rd_size;
                     hold_used_in = 1'b0;
                     state_in     = ST_MARK_WR;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end else if (fits) begin
               ok_in        = 1'b1;
               grant_in     = OffWidth'(start_ff + Hdr);
               idx_in       = idx_ff;
               hold_used_in = 1'b1;
               if (can_split) begin
                  used_in      = used_ff + UsedWidth'(need_ff + Hdr);
                  hold_size_in = SizeWidth'(need_ff);
                  size_in      = SizeWidth'(rd_size_w - need_ff - Hdr);
                  ptr_in       = count_ff;
                  count_in     = count_ff + CntOne;
                  state_in = (count_ff > idx_ff + CntOne) ? ST_SHIFT_REQ : ST_SPLIT_WR;
               end else begin
                  used_in      = used_ff + UsedWidth'(rd_size_w + Hdr);
                  hold_size_in = rd_size;
                  state_in     = ST_MARK_WR;
               end
            end
         end
         ST_SHIFT_REQ: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            // Move entry ptr-1 up to ptr, walking down toward idx+1.
            ptr_in   = ptr_ff - CntOne;
            state_in = (ptr_ff - CntOne > idx_ff + CntOne) ? ST_SHIFT_REQ : ST_SPLIT_WR;
         end
         ST_SPLIT_WR: begin
            // The remainder goes to idx+1; the granted part follows.
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            if (is_free_ff) begin
               idx_in       = '0;
               prev_free_in = 1'b0;
               state_in     = ST_MERGE_REQ;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_MERGE_REQ: begin
            state_in = (idx_ff < count_ff) ? ST_MERGE_CHK : ST_RESP;
         end
         ST_MERGE_CHK: begin
            // A free entry following a free one folds into it.
            if (fold) begin
               prev_size_in = fold_size;
               count_in     = count_ff - CntOne;
               ptr_in       = idx_ff;
               state_in     = (idx_ff + CntOne < count_ff) ? ST_PULL_REQ : ST_MERGE_REQ;
            end else begin
               prev_free_in = !rd_used;
               prev_size_in = rd_size;
               idx_in       = idx_ff + CntOne;
               state_in     = ST_MERGE_REQ;
            end
         end
         ST_PULL_REQ: state_in = ST_PULL_WR;
         ST_PULL_WR: begin
            // Move entry ptr+1 down to ptr until the new end of the table.
            ptr_in   = ptr_ff + CntOne;
            state_in = (ptr_ff + CntOne < count_ff) ? ST_PULL_REQ : ST_MERGE_REQ;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory port control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_lo;
      wr_en   = 1'b0;
      wr_addr = idx_lo;
      wr_size = size_ff;
      wr_used = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_size = FullSize;
            wr_used = 1'b0;
         end
         ST_SCAN_REQ, ST_MERGE_REQ: rd_en = 1'b1;
         ST_SHIFT_REQ: begin
            rd_en   = 1'b1;
            rd_addr = IdxWidth'(ptr_ff - CntOne);
         end
         ST_SHIFT_WR, ST_PULL_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[IdxWidth-1:0];
            wr_size = rd_size;
            wr_used = rd_used;
         end
         ST_PULL_REQ: begin
            rd_en   = 1'b1;
            rd_addr = IdxWidth'(ptr_ff + CntOne);
         end
         ST_SPLIT_WR: begin
            wr_en   = 1'b1;
            wr_addr = IdxWidth'(idx_ff + CntOne);
            wr_size = size_ff;
            wr_used = 1'b0;
         end
         ST_MARK_WR: begin
            wr_en   = 1'b1;
            wr_size = hold_size_ff;
            wr_used = hold_used_ff;
         end
         ST_MERGE_CHK: begin
            wr_en   = fold;
            wr_addr = IdxWidth'(idx_ff - CntOne);
            wr_size = fold_size;
            wr_used = 1'b0;
         end
         default: ;
      endcase
   end

   assign req_stall          = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_granted_offset = grant_ff;
   assign rsp_used_bytes     = used_ff;
   assign rsp_free_bytes     = PoolWord - used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= CntOne;
         used_ff      <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      ptr_ff       <= ptr_in;
      start_ff     <= start_in;
      need_ff      <= need_in;
      size_ff      <= size_in;
      prev_size_ff <= prev_size_in;
      prev_free_ff <= prev_free_in;
      hold_size_ff <= hold_size_in;
      hold_used_ff <= hold_used_in;
      is_free_ff   <= is_free_in;
      off_ff       <= off_in;
      grant_ff     <= grant_in;
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CntOne && count_ff <= CntMax)
      else $error("block count out of range");
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr_en)
      else $error("table written while idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(used_ff))
      else $error("stalled word changed");
`endif

endmodule
